### hdl/pas_pkg.sv
`default_nettype none

package pas_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int DIST_W  = PROD_W;
    localparam int COUNT_W = $clog2(MAX_POINTS + 1);
    localparam int PHASE_W = $clog2(MAX_POINTS);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic                         final_point;
    } pas_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         end_of_set;
        logic                         dropped;
    } pas_out_t;

    typedef struct packed {
        logic                         valid;
        logic                         anchor;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [DIFF_W-1:0]     dx;
        logic signed [DIFF_W-1:0]     dy;
        logic [DIST_W-1:0]            dist_sq;
    } pas_cell_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic sq;
        logic sum;
        logic mul;
        logic swap;
        logic shift;
    } pas_ctrl_t;

endpackage

`default_nettype wire

### hdl/polar_angle_point_sort.sv
// Channel   Ports                       Payload     Moves
// input     s_valid s_ready s_data      pas_in_t    one point per request
// result    m_valid m_ready m_data      pas_out_t   one emitted point per request
//
// Load: one point per cycle; s_ready is high only while loading.
// After the final point: prep states ST_DIFF, ST_SQ and ST_DIST, then
// MAX_POINTS odd-even transposition phases across the cell row (each an
// ST_MUL state for each cell's registered cross-product multipliers, then ST_SWAP).
// Emission: anchor, then the sorted points, one per cycle without stalls.
// Reset (aresetn low, synchronous) empties the row and clears set state.
// A stalled result holds in the output register; the row waits behind it.
`default_nettype none

module polar_angle_point_sort
    import pas_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pas_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output pas_out_t      m_data
);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_DIFF   = 3'd1;
    localparam logic [2:0] ST_SQ     = 3'd2;
    localparam logic [2:0] ST_DIST   = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_SWAP   = 3'd5;
    localparam logic [2:0] ST_EMIT_A = 3'd6;
    localparam logic [2:0] ST_EMIT_P = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic [PHASE_W-1:0]           phase_reg, phase_next;
    logic                         overflow_reg, overflow_next;
    logic signed [COORD_BITS-1:0] anchor_x_reg, anchor_x_next;
    logic signed [COORD_BITS-1:0] anchor_y_reg, anchor_y_next;
    logic                         m_valid_reg, m_valid_next;
    pas_out_t                     m_data_reg, m_data_next;

    pas_ctrl_t                    ctrl;
    logic                         accept, full, new_anchor, out_free;
    pas_cell_t                    in_cell;
    pas_cell_t                    cell_out [MAX_POINTS];
    pas_cell_t                    left_in  [MAX_POINTS];
    pas_cell_t                    right_in [MAX_POINTS];
    logic [MAX_POINTS-1:0]        swap_vec;
    logic [MAX_POINTS-1:0]        valid_vec;
    logic [MAX_POINTS-1:0]        anchor_vec;

    assign s_ready  = (state_reg == ST_LOAD);
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == COUNT_W'(MAX_POINTS));
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign new_anchor = (count_reg == '0) || (s_data.x_coord < anchor_x_reg) ||
                        ((s_data.x_coord == anchor_x_reg) && (s_data.y_coord < anchor_y_reg));

    always_comb begin
        in_cell        = '0;
        in_cell.valid  = 1'b1;
        in_cell.anchor = new_anchor;
        in_cell.x      = s_data.x_coord;
        in_cell.y      = s_data.y_coord;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
            localparam logic PARITY = 1'(gi % 2);
            logic left_swap;

            if (gi == 0) begin : g_head
                assign left_in[gi] = in_cell;
                assign left_swap   = 1'b0;
            end else begin : g_body
                always_comb begin
                    left_in[gi]        = cell_out[gi-1];
                    left_in[gi].anchor = cell_out[gi-1].anchor && !new_anchor;
                end
                assign left_swap = swap_vec[gi-1];
            end

            if (gi == MAX_POINTS - 1) begin : g_tail
                assign right_in[gi] = '0;
            end else begin : g_mid
                assign right_in[gi] = cell_out[gi+1];
            end

            pas_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .pair_left  (PARITY == phase_reg[0]),
                .left_cell  (left_in[gi]),
                .left_swap  (left_swap),
                .right_cell (right_in[gi]),
                .anchor_x   (anchor_x_reg),
                .anchor_y   (anchor_y_reg),
                .cur_cell   (cell_out[gi]),
                .swap       (swap_vec[gi])
            );

            assign valid_vec[gi]  = cell_out[gi].valid;
            assign anchor_vec[gi] = cell_out[gi].anchor;
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        overflow_next = overflow_reg;
        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ctrl          = '0;

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (new_anchor) begin
                            anchor_x_next = s_data.x_coord;
                            anchor_y_next = s_data.y_coord;
                        end
                    end
                    if (s_data.final_point) begin
                        count_next = '0;
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                ctrl.diff  = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                ctrl.sq    = 1'b1;
                state_next = ST_DIST;
            end
            ST_DIST: begin
                ctrl.sum   = 1'b1;
                phase_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                ctrl.mul   = 1'b1;
                state_next = ST_SWAP;
            end
            ST_SWAP: begin
                ctrl.swap = 1'b1;
                if (phase_reg == PHASE_W'(MAX_POINTS - 1)) begin
                    phase_next = '0;
                    state_next = ST_EMIT_A;
                end else begin
                    phase_next = phase_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT_A: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.out_x      = anchor_x_reg;
                    m_data_next.out_y      = anchor_y_reg;
                    m_data_next.end_of_set = !cell_out[0].valid;
                    m_data_next.dropped    = overflow_reg;
                    if (!cell_out[0].valid) begin
                        overflow_next = 1'b0;
                        state_next    = ST_LOAD;
                    end else begin
                        state_next    = ST_EMIT_P;
                    end
                end
            end
            ST_EMIT_P: begin
                if (out_free) begin
                    ctrl.shift             = 1'b1;
                    m_valid_next           = 1'b1;
                    m_data_next.out_x      = cell_out[0].x;
                    m_data_next.out_y      = cell_out[0].y;
                    m_data_next.end_of_set = !cell_out[1].valid;
                    m_data_next.dropped    = overflow_reg;
                    if (!cell_out[1].valid) begin
                        overflow_next = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            phase_reg    <= '0;
            overflow_reg <= 1'b0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            overflow_reg <= overflow_next;
            anchor_x_reg <= anchor_x_next;
            anchor_y_reg <= anchor_y_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_final_starts_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.final_point) |=> (state_reg == ST_DIFF))
        else $error("final point did not start the sort");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_row_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> ($countones(valid_vec) == int'(count_reg)))
        else $error("occupied cells disagree with point count");

    a_one_anchor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> $onehot0(anchor_vec))
        else $error("more than one cell marked as anchor");

    a_swap_keeps_points: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWAP) |=> ($countones(valid_vec) == $countones($past(valid_vec))))
        else $error("sort phase lost or created a point");
`endif

endmodule

`default_nettype wire

### hdl/pas_cell.sv
`default_nettype none

module pas_cell
    import pas_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pas_ctrl_t                    ctrl,
    input  wire logic                         pair_left,
    input  wire pas_cell_t                    left_cell,
    input  wire logic                         left_swap,
    input  wire pas_cell_t                    right_cell,
    input  wire logic signed [COORD_BITS-1:0] anchor_x,
    input  wire logic signed [COORD_BITS-1:0] anchor_y,
    output pas_cell_t                         cur_cell,
    output logic                              swap
);

    pas_cell_t                 cell_reg, cell_next;
    logic signed [PROD_W-1:0]  prod_a_reg, prod_a_next;
    logic signed [PROD_W-1:0]  prod_b_reg, prod_b_next;
    logic signed [DIFF_W-1:0]  op_a, op_b;
    logic signed [CROSS_W-1:0] xprod;
    logic [DIST_W-1:0]         dist_sum;
    logic                      goes_after;

    // shared multiplier pair: squares during prep, cross terms during sort
    assign op_a = ctrl.sq ? cell_reg.dx : right_cell.dy;
    assign op_b = ctrl.sq ? cell_reg.dy : right_cell.dx;

    assign prod_a_next = cell_reg.dx * op_a;
    assign prod_b_next = op_b * cell_reg.dy;

    assign xprod      = CROSS_W'(prod_a_reg) - CROSS_W'(prod_b_reg);
    assign dist_sum   = DIST_W'($unsigned(prod_a_reg)) + DIST_W'($unsigned(prod_b_reg));
    assign goes_after = (!xprod[CROSS_W-1] && (xprod != '0)) ||
                        ((xprod == '0) && (cell_reg.dist_sq > right_cell.dist_sq));

    // empty slots sort to the tail
    assign swap = pair_left && right_cell.valid && (!cell_reg.valid || goes_after);
    assign cur_cell = cell_reg;

    always_comb begin
        cell_next = cell_reg;
        if (ctrl.load) begin
            cell_next = left_cell;
        end
        if (ctrl.diff) begin
            cell_next.dx = DIFF_W'(cell_reg.x) - DIFF_W'(anchor_x);
            cell_next.dy = DIFF_W'(cell_reg.y) - DIFF_W'(anchor_y);
            if (cell_reg.anchor) begin
                cell_next.valid  = 1'b0;
                cell_next.anchor = 1'b0;
            end
        end
        if (ctrl.sum) begin
            cell_next.dist_sq = dist_sum;
        end
        if (ctrl.swap) begin
            if (swap) begin
                cell_next = right_cell;
            end else if (left_swap) begin
                cell_next = left_cell;
            end
        end
        if (ctrl.shift) begin
            cell_next = right_cell;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid  <= 1'b0;
            cell_reg.anchor <= 1'b0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sq || ctrl.mul) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

endmodule

`default_nettype wire
